### rtl/core/cdch_pkg.sv
// ----------------------------------------------------------------------------
// cdch_pkg
// Shared types, constants and arithmetic helpers for the concentric disk /
// cosine hemisphere warp.
// ----------------------------------------------------------------------------
package cdch_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int U_W           = 16;
	localparam int XY_W          = 18;
	localparam int Z_W           = 17;
	localparam int QW            = 30;
	localparam int DIV_STEPS     = 31;
	localparam int SQRT_STEPS    = 31;
	localparam int SIN_TERMS     = 5;
	localparam int COS_TERMS     = 6;

	localparam logic [30:0] Q_ONE   = 31'h4000_0000;
	localparam logic [30:0] Q_HALF  = 31'h2000_0000;
	localparam logic [29:0] PI4_Q30 = 30'd843314857;

	// Horner divisors with floor(2^sh/d) reciprocals, sh = 31 + floor(log2 d)
	localparam logic [7:0]  SIN_DIV [SIN_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [31:0] SIN_RCP [SIN_TERMS] = '{32'd1249445031, 32'd1908874353,
		32'd1636178017, 32'd1717986918, 32'd1431655765};
	localparam int          SIN_SH  [SIN_TERMS] = '{37, 37, 36, 35, 33};
	localparam logic [7:0]  COS_DIV [COS_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
	localparam logic [31:0] COS_RCP [COS_TERMS] = '{32'd2082408385, 32'd1527099483,
		32'd1227133513, 32'd1145324612, 32'd1431655765, 32'd2147483648};
	localparam int          COS_SH  [COS_TERMS] = '{38, 37, 36, 35, 34, 32};

	// den is a Q15 magnitude up to 1.0, held in 17 bits
	typedef struct packed {
		logic        origin;
		logic        first;
		logic        rneg;
		logic        aneg;
		logic [16:0] den;
	} side_t;

	// Q30 product, rounded half up
	function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = 62'(a) * 62'(b) + 62'(Q_HALF);
		return 31'(p >> QW);
	endfunction

	// quotient estimate, low by at most one
	function automatic logic [30:0] rcp_div(input logic [30:0] p, input logic [31:0] m,
			input int sh);
		logic [62:0] pr;
		pr = 63'(p) * 63'(m);
		return 31'(pr >> sh);
	endfunction

	// fix the estimate, then one Horner term: 1 - p/d
	function automatic logic [30:0] hstep(input logic [30:0] p, input logic [30:0] qe,
			input logic [7:0] d);
		logic [38:0] qd;
		logic [30:0] rm;
		logic [30:0] q;
		qd = 39'(qe) * 39'(d);
		rm = p - 31'(qd);
		q  = (rm >= 31'(d)) ? qe + 31'd1 : qe;
		return Q_ONE - q;
	endfunction

	// Q30 magnitude to Q1.frac, half up, saturated at 1.0
	function automatic logic [30:0] to_out(input logic [30:0] m, input int frac);
		logic [31:0] r;
		logic [31:0] lim;
		r   = {1'b0, m};
		lim = 32'd1 << frac;
		if (QW - frac > 0) begin
			r = (r + (32'd1 << (QW - frac - 1))) >> (QW - frac);
		end
		return (r > lim) ? 31'(lim) : 31'(r);
	endfunction

endpackage

### rtl/core/cdch_ifs.sv
// ----------------------------------------------------------------------------
// cdch channel interfaces
// Sample-pair input channel and direction output channel, valid/ready.
// ----------------------------------------------------------------------------
interface cdch_in_if;
	logic                        valid;
	logic                        ready;
	logic [cdch_pkg::U_W-1:0]    u_first;
	logic [cdch_pkg::U_W-1:0]    u_second;

	modport source (output valid, output u_first, output u_second, input ready);
	modport sink   (input valid, input u_first, input u_second, output ready);
endinterface

interface cdch_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [cdch_pkg::XY_W-1:0]   dir_x;
	logic signed [cdch_pkg::XY_W-1:0]   dir_y;
	logic        [cdch_pkg::Z_W-1:0]    dir_z;

	modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

### rtl/core/cdch_div.sv
// ----------------------------------------------------------------------------
// cdch_div
// Pipelined restoring divider, one quotient bit per stage: (num << 30) / den.
// ----------------------------------------------------------------------------
module cdch_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                v_i,
	input  cdch_pkg::side_t     side_i,
	input  logic [16:0]         num_i,
	output logic                v_o,
	output cdch_pkg::side_t     side_o,
	output logic [30:0]         quo_o
);
	import cdch_pkg::*;

	logic        v_s    [0:DIV_STEPS];
	side_t       side_s [0:DIV_STEPS];
	logic [16:0] rem_s  [0:DIV_STEPS];
	logic [30:0] quo_s  [0:DIV_STEPS];

	assign v_s[0]    = v_i;
	assign side_s[0] = side_i;
	assign rem_s[0]  = num_i;
	assign quo_s[0]  = '0;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [17:0] r2;
		logic        ge;
		logic [17:0] nrem;

		// first step compares num itself: quotient bit for 1.0
		if (k == 0) begin : g_first
			assign r2 = {1'b0, rem_s[k]};
		end else begin : g_next
			assign r2 = {rem_s[k], 1'b0};
		end
		assign ge   = (r2 >= {1'b0, side_s[k].den});
		assign nrem = ge ? r2 - {1'b0, side_s[k].den} : r2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= side_s[k];
				rem_s[k+1]  <= nrem[16:0];
				quo_s[k+1]  <= {quo_s[k][29:0], ge};
			end
		end
	end

	assign v_o    = v_s[DIV_STEPS];
	assign side_o = side_s[DIV_STEPS];
	assign quo_o  = quo_s[DIV_STEPS];

endmodule

### rtl/core/cdch_trig.sv
// ----------------------------------------------------------------------------
// cdch_trig
// Angle scaling and pipelined Horner sin/cos. Each term takes three stages:
// product, reciprocal estimate, correction.
// ----------------------------------------------------------------------------
module cdch_trig (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                v_i,
	input  cdch_pkg::side_t     side_i,
	input  logic [30:0]         t_i,
	output logic                v_o,
	output cdch_pkg::side_t     side_o,
	output logic [30:0]         cos_o,
	output logic [30:0]         sin_o
);
	import cdch_pkg::*;

	logic        v_s1, v_s2;
	side_t       side_s1, side_s2;
	logic [29:0] am_s1, am_s2, a2_s2;
	logic [60:0] am_prod;
	logic [30:0] a2_n;

	assign am_prod = 61'(t_i) * 61'(PI4_Q30) + 61'(Q_HALF);
	assign a2_n    = mulq({1'b0, am_s1}, {1'b0, am_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_i;
			am_s1   <= 30'(am_prod >> QW);
			side_s2 <= side_s1;
			am_s2   <= am_s1;
			a2_s2   <= a2_n[29:0];
		end
	end

	logic        st_v    [0:COS_TERMS];
	side_t       st_side [0:COS_TERMS];
	logic [29:0] st_am   [0:COS_TERMS];
	logic [29:0] st_a2   [0:COS_TERMS];
	logic [30:0] st_hs   [0:COS_TERMS];
	logic [30:0] st_hc   [0:COS_TERMS];

	assign st_v[0]    = v_s2;
	assign st_side[0] = side_s2;
	assign st_am[0]   = am_s2;
	assign st_a2[0]   = a2_s2;
	assign st_hs[0]   = Q_ONE;
	assign st_hc[0]   = Q_ONE;

	for (genvar j = 0; j < COS_TERMS; j++) begin : g_term
		logic        vp_s, vr_s;
		side_t       sp_s, sr_s;
		logic [29:0] amp_s, amr_s, a2p_s, a2r_s;
		logic [30:0] pc_p_s, pc_r_s, qc_r_s;
		logic [30:0] ps_p_s, ps_r_s, qs_r_s;
		logic [30:0] pc_n, qc_n, hc_n;
		logic [30:0] ps_n, qs_n, hs_n;

		assign pc_n = mulq({1'b0, st_a2[j]}, st_hc[j]);
		assign qc_n = rcp_div(pc_p_s, COS_RCP[j], COS_SH[j]);
		assign hc_n = hstep(pc_r_s, qc_r_s, COS_DIV[j]);

		// sin runs one term shorter; its last slot multiplies by the angle
		if (j < SIN_TERMS) begin : g_sin
			assign ps_n = mulq({1'b0, st_a2[j]}, st_hs[j]);
			assign qs_n = rcp_div(ps_p_s, SIN_RCP[j], SIN_SH[j]);
			assign hs_n = hstep(ps_r_s, qs_r_s, SIN_DIV[j]);
		end else begin : g_fin
			assign ps_n = mulq({1'b0, st_am[j]}, st_hs[j]);
			assign qs_n = ps_p_s;
			assign hs_n = qs_r_s;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vp_s      <= 1'b0;
				vr_s      <= 1'b0;
				st_v[j+1] <= 1'b0;
			end else if (adv) begin
				vp_s      <= st_v[j];
				vr_s      <= vp_s;
				st_v[j+1] <= vr_s;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sp_s   <= st_side[j];
				amp_s  <= st_am[j];
				a2p_s  <= st_a2[j];
				pc_p_s <= pc_n;
				ps_p_s <= ps_n;

				sr_s   <= sp_s;
				amr_s  <= amp_s;
				a2r_s  <= a2p_s;
				pc_r_s <= pc_p_s;
				qc_r_s <= qc_n;
				ps_r_s <= ps_p_s;
				qs_r_s <= qs_n;

				st_side[j+1] <= sr_s;
				st_am[j+1]   <= amr_s;
				st_a2[j+1]   <= a2r_s;
				st_hc[j+1]   <= hc_n;
				st_hs[j+1]   <= hs_n;
			end
		end
	end

	assign v_o    = st_v[COS_TERMS];
	assign side_o = st_side[COS_TERMS];
	assign cos_o  = st_hc[COS_TERMS];
	assign sin_o  = st_hs[COS_TERMS];

endmodule

### rtl/core/concentric_disk_cosine_hemisphere_unit.sv
// ----------------------------------------------------------------------------
// concentric_disk_cosine_hemisphere_unit
// Concentric square-to-disk warp with optional cosine hemisphere lift.
// ----------------------------------------------------------------------------
// Takes one sample pair per cycle while in_ch.ready is high and returns one
// direction per pair, in order. The path is a single stalling pipeline:
// input mapping, 31 divider stages (one quotient bit each), 20 stages of angle
// and Horner sin/cos, 3 stages of scaling and squaring, 31 square-root stages
// (one result bit each) and the output register. in_ch.ready drops only while
// the output register holds a word that out_ch has not taken. output_mode is
// cfg_wdata, written when cfg_we is high; set it only while the pipe is empty.
module concentric_disk_cosine_hemisphere_unit #(
	parameter int FRAC_BITS = cdch_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	cdch_in_if.sink           in_ch,
	cdch_out_if.source        out_ch
);
	import cdch_pkg::*;

	logic adv;
	logic mode_q;
	logic out_v_q;

	assign adv         = ~out_v_q | out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// stage 1: map to [-1,1], pick branch
	logic signed [16:0] dx, dy;
	logic [16:0]        ax, ay;
	logic [16:0]        mx, my;
	logic               first_n;
	side_t              side_n;
	logic               v_s1;
	side_t              side_s1;
	logic [16:0]        num_s1;

	assign dx = signed'({1'b0, in_ch.u_first})  - 17'sd32768;
	assign dy = signed'({1'b0, in_ch.u_second}) - 17'sd32768;
	assign ax = dx[16] ? 17'(-dx) : 17'(dx);
	assign ay = dy[16] ? 17'(-dy) : 17'(dy);
	assign mx = ax;
	assign my = ay;
	assign first_n = (mx > my);

	always_comb begin
		side_n.first  = first_n;
		side_n.den    = first_n ? mx : my;
		side_n.origin = (side_n.den == 17'd0);
		side_n.rneg   = first_n ? dx[16] : dy[16];
		side_n.aneg   = dx[16] ^ dy[16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_n;
			num_s1  <= first_n ? my : mx;
		end
	end

	logic        dv_v;
	side_t       dv_side;
	logic [30:0] dv_quo;

	cdch_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_i    (v_s1),
		.side_i (side_s1),
		.num_i  (num_s1),
		.v_o    (dv_v),
		.side_o (dv_side),
		.quo_o  (dv_quo)
	);

	logic        tr_v;
	side_t       tr_side;
	logic [30:0] tr_cos, tr_sin;

	cdch_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_i    (dv_v),
		.side_i (dv_side),
		.t_i    (dv_quo),
		.v_o    (tr_v),
		.side_o (tr_side),
		.cos_o  (tr_cos),
		.sin_o  (tr_sin)
	);

	// scale by radius (den is the Q15 sample magnitude), clamp, place
	logic [46:0] pc_w, ps_w;
	logic [30:0] pc, ps;
	logic [30:0] xm_n, ym_n;
	logic        xn_n, yn_n;

	assign pc_w = 47'(tr_side.den) * 47'(tr_cos) + 47'd16384;
	assign ps_w = 47'(tr_side.den) * 47'(tr_sin) + 47'd16384;
	assign pc   = ((pc_w >> 15) > 47'(Q_ONE)) ? Q_ONE : 31'(pc_w >> 15);
	assign ps   = ((ps_w >> 15) > 47'(Q_ONE)) ? Q_ONE : 31'(ps_w >> 15);

	always_comb begin
		if (tr_side.origin) begin
			xm_n = '0;
			ym_n = '0;
			xn_n = 1'b0;
			yn_n = 1'b0;
		end else if (tr_side.first) begin
			xm_n = pc;
			ym_n = ps;
			xn_n = tr_side.rneg;
			yn_n = tr_side.rneg ^ tr_side.aneg;
		end else begin
			xm_n = ps;
			ym_n = pc;
			xn_n = tr_side.rneg ^ tr_side.aneg;
			yn_n = tr_side.rneg;
		end
	end

	logic        v_s2, v_s3, v_s4;
	logic [30:0] xm_s2, ym_s2, xm_s3, ym_s3, xm_s4, ym_s4;
	logic        xn_s2, yn_s2, xn_s3, yn_s3, xn_s4, yn_s4;
	logic [61:0] xx_s3, yy_s3;
	logic [61:0] rad_s4;
	logic [62:0] sq;

	assign sq = 63'(xx_s3) + 63'(yy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= tr_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xm_s2  <= xm_n;
			ym_s2  <= ym_n;
			xn_s2  <= xn_n;
			yn_s2  <= yn_n;
			xm_s3  <= xm_s2;
			ym_s3  <= ym_s2;
			xn_s3  <= xn_s2;
			yn_s3  <= yn_s2;
			xx_s3  <= 62'(xm_s2) * 62'(xm_s2);
			yy_s3  <= 62'(ym_s2) * 62'(ym_s2);
			xm_s4  <= xm_s3;
			ym_s4  <= ym_s3;
			xn_s4  <= xn_s3;
			yn_s4  <= yn_s3;
			rad_s4 <= (sq < (63'd1 << 60)) ? 62'((63'd1 << 60) - sq) : 62'd0;
		end
	end

	// digit-by-digit square root, one result bit per stage
	logic        sr_v   [0:SQRT_STEPS];
	logic [61:0] sr_rad [0:SQRT_STEPS];
	logic [61:0] sr_res [0:SQRT_STEPS];
	logic [30:0] sr_xm  [0:SQRT_STEPS];
	logic [30:0] sr_ym  [0:SQRT_STEPS];
	logic        sr_xn  [0:SQRT_STEPS];
	logic        sr_yn  [0:SQRT_STEPS];

	assign sr_v[0]   = v_s4;
	assign sr_rad[0] = rad_s4;
	assign sr_res[0] = '0;
	assign sr_xm[0]  = xm_s4;
	assign sr_ym[0]  = ym_s4;
	assign sr_xn[0]  = xn_s4;
	assign sr_yn[0]  = yn_s4;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [61:0] BIT_K = 62'd1 << (2 * (SQRT_STEPS - 1 - k));
		logic [61:0] trial;
		logic        ge;

		assign trial = sr_res[k] + BIT_K;
		assign ge    = (sr_rad[k] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v[k+1] <= 1'b0;
			end else if (adv) begin
				sr_v[k+1] <= sr_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sr_rad[k+1] <= ge ? sr_rad[k] - trial : sr_rad[k];
				sr_res[k+1] <= ge ? (sr_res[k] >> 1) + BIT_K : (sr_res[k] >> 1);
				sr_xm[k+1]  <= sr_xm[k];
				sr_ym[k+1]  <= sr_ym[k];
				sr_xn[k+1]  <= sr_xn[k];
				sr_yn[k+1]  <= sr_yn[k];
			end
		end
	end

	// output register: round, saturate, apply sign
	logic [30:0] xo, yo, zo;
	logic [31:0] xo_w, yo_w;
	logic signed [XY_W-1:0] dir_x_q, dir_y_q;
	logic [Z_W-1:0]         dir_z_q;

	assign xo   = to_out(sr_xm[SQRT_STEPS], FRAC_BITS);
	assign yo   = to_out(sr_ym[SQRT_STEPS], FRAC_BITS);
	assign zo   = to_out(sr_res[SQRT_STEPS][30:0], FRAC_BITS);
	assign xo_w = (sr_xn[SQRT_STEPS] && xo != '0) ? 32'd0 - {1'b0, xo} : {1'b0, xo};
	assign yo_w = (sr_yn[SQRT_STEPS] && yo != '0) ? 32'd0 - {1'b0, yo} : {1'b0, yo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= sr_v[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_x_q <= signed'(XY_W'(xo_w));
			dir_y_q <= signed'(XY_W'(yo_w));
			dir_z_q <= mode_q ? Z_W'(zo) : '0;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.dir_x = dir_x_q;
	assign out_ch.dir_y = dir_y_q;
	assign out_ch.dir_z = dir_z_q;

endmodule

### rtl/core/cdch_checker.sv
// ----------------------------------------------------------------------------
// cdch_checker
// Port-level checks on the warp unit's handshake and stall behavior.
// ----------------------------------------------------------------------------
module cdch_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [cdch_pkg::XY_W-1:0] dir_x,
	input logic signed [cdch_pkg::XY_W-1:0] dir_y,
	input logic        [cdch_pkg::Z_W-1:0]  dir_z
);

	// a word waiting at the output stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dir_x) && $stable(dir_y)
			&& $stable(dir_z))
		else $error("output word dropped or changed while stalled");

	// pipe only stalls on a blocked output word
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled while output word drains");

	// output register is empty right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind concentric_disk_cosine_hemisphere_unit cdch_checker u_cdch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.dir_x     (out_ch.dir_x),
	.dir_y     (out_ch.dir_y),
	.dir_z     (out_ch.dir_z)
);
